[rtl/core/i2bn_pkg.sv]
// ---------------------------------------------------------------------------
// i2bn_pkg
// Shared types and constants for the integer to base-N digit unit.
// ---------------------------------------------------------------------------
`default_nettype none

package i2bn_pkg;

    // radix register
    localparam int RADIX_W     = 5;
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_RESET = 10;

    // result word field widths
    localparam int DIGIT_OUT_W = 5;
    localparam int CHAR_W      = 7;

    // character mapping: '0'..'9', then 'A' and up
    localparam int DIGIT_MAX_DEC = 9;
    localparam int CHAR_ZERO     = 48;
    localparam int CHAR_ALPHA    = 55;  // 'A' - 10

    // one result word
    typedef struct packed {
        logic [DIGIT_OUT_W-1:0] digit;
        logic [CHAR_W-1:0]      char_code;
        logic                   last_digit;
    } t_result;

    // ASCII code of a digit (digit up to 35)
    function automatic logic [CHAR_W-1:0] char_of(input logic [5:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d <= 6'(DIGIT_MAX_DEC)) begin
            return CHAR_W'(CHAR_ZERO) + d_ext;
        end
        return CHAR_W'(CHAR_ALPHA) + d_ext;
    endfunction

endpackage

`default_nettype wire

[rtl/core/i2bn_queue.sv]
// ---------------------------------------------------------------------------
// i2bn_queue
// Small synchronous FIFO with push/full and pop/empty handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module i2bn_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2bn_front.sv]
// ---------------------------------------------------------------------------
// i2bn_front
// Input side: holds the radix register (clamped on write) and classifies
// each incoming value. Non-positive values are reduced to zero magnitude,
// which the back end turns into the single digit 0.
// ---------------------------------------------------------------------------
`default_nettype none

module i2bn_front #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_RADIX   = 20
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [i2bn_pkg::RADIX_W-1:0]    i_cfg_wr_data,
    input  wire logic                            i_push,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_value,
    output logic                                 o_full,
    output logic                                 o_q_push,
    output logic [VALUE_WIDTH-2:0]               o_q_mag,
    input  wire logic                            i_q_full,
    output logic [i2bn_pkg::RADIX_W-1:0]         o_radix
);

    import i2bn_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] n_radix;

    // clamp the written base to RADIX_MIN..MAX_RADIX
    always_comb begin
        n_radix = i_cfg_wr_data;
        if (32'(i_cfg_wr_data) < 32'(RADIX_MIN)) begin
            n_radix = RADIX_W'(RADIX_MIN);
        end else if (32'(i_cfg_wr_data) > 32'(MAX_RADIX)) begin
            n_radix = RADIX_W'(MAX_RADIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_W'(RADIX_RESET);
        end else if (i_cfg_wr_en) begin
            r_radix <= n_radix;
        end
    end

    assign o_radix = r_radix;

    // classify: sign bit set means nothing to convert but a zero
    assign o_full   = i_q_full;
    assign o_q_push = i_push;
    assign o_q_mag  = i_value[VALUE_WIDTH-1] ? '0 : i_value[VALUE_WIDTH-2:0];

endmodule

`default_nettype wire

[rtl/core/i2bn_back.sv]
// ---------------------------------------------------------------------------
// i2bn_back
// Conversion engine. Searches upward for the highest power of the base not
// above the value, stacking each smaller power; then extracts each digit by
// repeated subtraction, popping the next lower power from the stack.
// ---------------------------------------------------------------------------
`default_nettype none

module i2bn_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_RADIX   = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [i2bn_pkg::RADIX_W-1:0] i_radix,
    input  wire logic                         i_mid_empty,
    input  wire logic [VALUE_WIDTH-2:0]       i_mag,
    output logic                              o_mid_pop,
    input  wire logic                         i_res_full,
    output logic                              o_res_push,
    output i2bn_pkg::t_result                 o_res_data
);

    import i2bn_pkg::*;

    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int PROD_W      = MAG_W + RADIX_W;
    localparam int STACK_DEPTH = VALUE_WIDTH - 2;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIGIT_W     = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DIGIT,
        S_LOAD
    } t_state;

    t_state             r_state, n_state;
    logic [MAG_W-1:0]   r_rem, n_rem;
    logic [MAG_W-1:0]   r_pow, n_pow;
    logic [PROD_W-1:0]  r_next, n_next;
    logic [CNT_W-1:0]   r_sp, n_sp;
    logic [DIGIT_W-1:0] r_d, n_d;
    logic [MAG_W-1:0]   r_rd_pow;
    logic [MAG_W-1:0]   r_stack [STACK_DEPTH];

    logic [PROD_W-1:0]  w_prod;
    logic [CNT_W-1:0]   w_sp_dec;
    logic [5:0]         w_d6;
    logic               w_mem_we;
    logic               w_mem_re;

    // next candidate power, registered before it is compared
    assign w_prod   = r_next[MAG_W-1:0] * i_radix;
    assign w_sp_dec = r_sp - CNT_W'(1);
    assign w_d6     = 6'(r_d);

    // result word for the current place
    assign o_res_data.digit      = w_d6[DIGIT_OUT_W-1:0];
    assign o_res_data.char_code  = char_of(w_d6);
    assign o_res_data.last_digit = (r_sp == '0);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_rem      = r_rem;
        n_pow      = r_pow;
        n_next     = r_next;
        n_sp       = r_sp;
        n_d        = r_d;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        o_mid_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_mid_empty) begin
                    o_mid_pop = 1'b1;
                    n_rem     = i_mag;
                    n_pow     = MAG_W'(1);
                    n_next    = PROD_W'(i_radix);
                    n_sp      = '0;
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // climb while base * power still fits in the value
                if (r_next <= PROD_W'(r_rem)) begin
                    w_mem_we = 1'b1;
                    n_sp     = r_sp + CNT_W'(1);
                    n_pow    = r_next[MAG_W-1:0];
                    n_next   = w_prod;
                end else begin
                    n_d     = '0;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (r_rem >= r_pow) begin
                    n_rem = r_rem - r_pow;
                    n_d   = r_d + DIGIT_W'(1);
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_sp == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_mem_re = 1'b1;
                        n_sp     = w_sp_dec;
                        n_state  = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_pow   = r_rd_pow;
                n_d     = '0;
                n_state = S_DIGIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
        r_rem  <= n_rem;
        r_pow  <= n_pow;
        r_next <= n_next;
        r_d    <= n_d;
    end

    // power stack, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_stack[r_sp[IDX_W-1:0]] <= r_pow;
        end
        if (w_mem_re) begin
            r_rd_pow <= r_stack[w_sp_dec[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

[rtl/core/integer_to_base_n_digits_unit.sv]
// ---------------------------------------------------------------------------
// integer_to_base_n_digits_unit
// Converts signed integers to digits in a base of 2..MAX_RADIX.
//
// Input channel: push/full. A word is taken at a clock edge with push high
// and full low. Result channel: empty/pop. The oldest digit word sits on
// o_digit, o_char_code and o_last_digit while empty is low; pop takes it.
// Each value yields its digits most significant first, o_last_digit on the
// units digit. Zero or negative values yield the single digit 0.
// The base is written through i_cfg_wr_en/i_cfg_wr_data (clamped, reset 10).
//
// Operation: one value at a time in the engine. It takes the value, steps
// through the power search, then for each digit subtracts repeatedly and
// pushes the digit, loading the next lower power from the stack between
// digits. Two-entry queues sit before and after the engine, so input
// keeps being taken and the engine keeps running while results wait to be
// popped; when the result queue is full the engine holds its digit.
// Reset (synchronous, active low) empties both queues and idles the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_base_n_digits_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_RADIX   = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [i2bn_pkg::RADIX_W-1:0]        i_cfg_wr_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [VALUE_WIDTH-1:0]       i_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [i2bn_pkg::DIGIT_OUT_W-1:0]         o_digit,
    output logic [i2bn_pkg::CHAR_W-1:0]              o_char_code,
    output logic                                     o_last_digit
);

    import i2bn_pkg::*;

    localparam int MAG_W   = VALUE_WIDTH - 1;
    localparam int Q_DEPTH = 2;
    localparam int RES_W   = $bits(t_result);

    logic               w_mid_push;
    logic [MAG_W-1:0]   w_mid_wdata;
    logic               w_mid_full;
    logic               w_mid_pop;
    logic [MAG_W-1:0]   w_mid_rdata;
    logic               w_mid_empty;
    logic [RADIX_W-1:0] w_radix;
    logic               w_res_push;
    logic               w_res_full;
    t_result            w_res_wdata;
    t_result            w_res_rdata;

    // front: config register and input classification
    i2bn_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (push),
        .i_value       (i_value),
        .o_full        (full),
        .o_q_push      (w_mid_push),
        .o_q_mag       (w_mid_wdata),
        .i_q_full      (w_mid_full),
        .o_radix       (w_radix)
    );

    // queue between front and engine
    i2bn_queue #(
        .DATA_W (MAG_W),
        .DEPTH  (Q_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_wdata),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_rdata),
        .o_empty (w_mid_empty)
    );

    // conversion engine
    i2bn_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (w_radix),
        .i_mid_empty (w_mid_empty),
        .i_mag       (w_mid_rdata),
        .o_mid_pop   (w_mid_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_wdata)
    );

    // result queue
    i2bn_queue #(
        .DATA_W (RES_W),
        .DEPTH  (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_wdata),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_rdata),
        .o_empty (empty)
    );

    assign o_digit      = w_res_rdata.digit;
    assign o_char_code  = w_res_rdata.char_code;
    assign o_last_digit = w_res_rdata.last_digit;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to base-N digit unit.
//
// Values go in through the push/full side and are converted with the radix
// held in the bench. The expected digit words are queued at the moment a
// value is taken. Each popped word is compared field by field with the
// oldest queued one. Directed values cover the field extremes, radix clamping
// and exact powers. Random traffic follows in three phases of idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2bn_pkg::*;

    localparam int VALUE_W   = 32;
    localparam int MAX_RADIX = 20;
    localparam int WORDS_PER_PHASE = 21;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [RADIX_W-1:0]        i_cfg_wr_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [DIGIT_OUT_W-1:0]    o_digit;
    logic [CHAR_W-1:0]         o_char_code;
    logic                      o_last_digit;

    // bench copy of the radix register
    int unsigned radix_now = RADIX_RESET;
    t_result     expected_digits[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    integer_to_base_n_digits_unit #(
        .VALUE_WIDTH (VALUE_W),
        .MAX_RADIX   (MAX_RADIX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_value       (i_value),
        .empty         (empty),
        .pop           (pop),
        .o_digit       (o_digit),
        .o_char_code   (o_char_code),
        .o_last_digit  (o_last_digit)
    );

    always #5 i_clk = ~i_clk;

    // queue the digit words of one value, most significant first
    task automatic predict_digits(input logic signed [VALUE_W-1:0] v);
        longint unsigned rest;
        longint unsigned weight;
        t_result         r;
        int unsigned     d;
        if (v <= 0) begin
            r.digit      = '0;
            r.char_code  = CHAR_W'(CHAR_ZERO);
            r.last_digit = 1'b1;
            expected_digits.push_back(r);
            return;
        end
        rest   = longint'(v);
        weight = 1;
        while (weight <= rest / radix_now) weight = weight * radix_now;
        do begin
            d = 0;
            while (rest >= weight) begin
                rest = rest - weight;
                d++;
            end
            r.digit      = DIGIT_OUT_W'(d);
            r.char_code  = (d <= DIGIT_MAX_DEC) ? CHAR_W'(CHAR_ZERO + d)
                                                : CHAR_W'(CHAR_ALPHA + d);
            r.last_digit = (weight == 1);
            expected_digits.push_back(r);
            weight = weight / radix_now;
        end while (weight != 0);
    endtask

    // offer one word; entered and left at a falling edge
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_digits(v);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every expected word has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (expected_digits.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // radix write, only with the unit idle
    task automatic write_radix(input logic [RADIX_W-1:0] w);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (w < RADIX_MIN)
            radix_now = RADIX_MIN;
        else if (w > MAX_RADIX)
            radix_now = MAX_RADIX;
        else
            radix_now = w;
    endtask

    // mix of full-width, small, negative and near-power values
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned     pick;
        longint unsigned p;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom;
        if (pick < 60)
            return $urandom_range(0, 5000);
        if (pick < 70)
            return -$urandom_range(1, 1000);
        if (pick < 92) begin
            p = 1;
            repeat ($urandom_range(0, 30)) begin
                if (p * radix_now <= 64'h7fff_ffff) p = p * radix_now;
            end
            if (p == 1 || $urandom_range(1)) return VALUE_W'(p);
            return VALUE_W'(p - 1);
        end
        return {1'b0, {(VALUE_W-1){1'b1}}};
    endfunction

    // default radix: zero, negatives, extremes, exact power
    task automatic test_default_radix();
        send_value(0);
        send_value(-1);
        send_value(32'sh8000_0000);
        send_value(1);
        send_value(9);
        send_value(10);
        send_value(1000000000);
        send_value(32'sh7fff_ffff);
    endtask

    // writes below the range take radix 2
    task automatic test_radix_clamp_low();
        write_radix(5'd0);
        send_value(1);
        send_value(32'sh4000_0000);
        send_value(32'sh7fff_ffff);
        write_radix(5'd1);
        send_value(6);
    endtask

    // writes above the range take the top radix; letters up to J
    task automatic test_radix_clamp_high();
        write_radix(5'd31);
        send_value(19);
        send_value(20);
        send_value(400);
        send_value(32'sh7fff_ffff);
        send_value(32'shbebc_2000);
        write_radix(5'd21);
        send_value(13);
        write_radix(5'(MAX_RADIX));
        send_value(1280000000);
        write_radix(5'd16);
        send_value(32'sh7edc_ba98);
        send_value(32'sh0000_0abc);
    endtask

    // random values over a few radix settings
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (5) begin
            write_radix(RADIX_W'($urandom_range(0, 31)));
            repeat (WORDS_PER_PHASE) send_value(random_value());
        end
    endtask

    // receiver: pop with random stalls
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each popped word with the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (pop && !empty) begin
            if (expected_digits.size() == 0) begin
                $display("%0t ns: word with none expected: digit %0d char %0d last %0b",
                         $time, o_digit, o_char_code, o_last_digit);
                mismatch_count++;
            end else begin
                want = expected_digits.pop_front();
                if (o_digit !== want.digit) begin
                    $display("%0t ns: digit expected %0d actual %0d",
                             $time, want.digit, o_digit);
                    mismatch_count++;
                end
                if (o_char_code !== want.char_code) begin
                    $display("%0t ns: char_code expected %0d actual %0d",
                             $time, want.char_code, o_char_code);
                    mismatch_count++;
                end
                if (o_last_digit !== want.last_digit) begin
                    $display("%0t ns: last_digit expected %0b actual %0b",
                             $time, want.last_digit, o_last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_radix();
        test_radix_clamp_low();
        test_radix_clamp_high();
        test_random_traffic(17, 79);
        test_random_traffic(79, 17);
        test_random_traffic(0, 0);
        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
